// ===== hw/rtl/aie_pkg.sv =====
// shared types and codes of the integer execute unit
package aie_pkg;

	localparam logic [5:0] OP_ADD_IMM  = 6'd1;
	localparam logic [5:0] OP_ADDS_IMM = 6'd2;
	localparam logic [5:0] OP_SUB_IMM  = 6'd3;
	localparam logic [5:0] OP_SUBS_IMM = 6'd4;
	localparam logic [5:0] OP_ADD_REG  = 6'd5;
	localparam logic [5:0] OP_ADDS_REG = 6'd6;
	localparam logic [5:0] OP_SUB_REG  = 6'd7;
	localparam logic [5:0] OP_SUBS_REG = 6'd8;
	localparam logic [5:0] OP_AND      = 6'd9;
	localparam logic [5:0] OP_BIC      = 6'd13;
	localparam logic [5:0] OP_BICS     = 6'd16;
	localparam logic [5:0] OP_AND_IMM  = 6'd17;
	localparam logic [5:0] OP_EOR_IMM  = 6'd19;
	localparam logic [5:0] OP_ANDS_IMM = 6'd20;
	localparam logic [5:0] OP_SBFM     = 6'd21;
	localparam logic [5:0] OP_BFM      = 6'd22;
	localparam logic [5:0] OP_UBFM     = 6'd23;
	localparam logic [5:0] OP_MOVN     = 6'd24;
	localparam logic [5:0] OP_MOVZ     = 6'd25;
	localparam logic [5:0] OP_MOVK     = 6'd26;
	localparam logic [5:0] OP_ADR      = 6'd27;
	localparam logic [5:0] OP_ADRP     = 6'd28;
	localparam logic [5:0] OP_CSEL     = 6'd29;
	localparam logic [5:0] OP_CSINC    = 6'd30;
	localparam logic [5:0] OP_CSINV    = 6'd31;
	localparam logic [5:0] OP_CSNEG    = 6'd32;
	localparam logic [5:0] OP_UDIV     = 6'd33;
	localparam logic [5:0] OP_SDIV     = 6'd34;
	localparam logic [5:0] OP_LSLV     = 6'd35;
	localparam logic [5:0] OP_RORV     = 6'd38;
	localparam logic [5:0] OP_B        = 6'd39;
	localparam logic [5:0] OP_BL       = 6'd40;
	localparam logic [5:0] OP_BR       = 6'd41;
	localparam logic [5:0] OP_BLR      = 6'd42;
	localparam logic [5:0] OP_RET      = 6'd43;
	localparam logic [5:0] OP_BCOND    = 6'd44;
	localparam logic [5:0] OP_CBZ      = 6'd45;
	localparam logic [5:0] OP_CBNZ     = 6'd46;
	localparam logic [5:0] OP_TBZ      = 6'd47;
	localparam logic [5:0] OP_TBNZ     = 6'd48;
	localparam logic [5:0] OP_SVC      = 6'd49;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	localparam logic [4:0] REG_ZR_SP = 5'd31;
	localparam logic [4:0] REG_LINK  = 5'd30;

	typedef struct packed {
		logic [3:0]  condition;
		logic [63:0] field_top_mask;
		logic [63:0] field_write_mask;
		logic [5:0]  bit_index;
		logic [5:0]  shift_amount;
		logic [1:0]  shift_kind;
		logic [63:0] immediate;
		logic [4:0]  second_reg;
		logic [4:0]  first_reg;
		logic [4:0]  dest_reg;
		logic        is_64bit;
		logic [5:0]  op;
	} instr_t;

	// classified request as it waits in the queue
	typedef struct packed {
		instr_t ins;
		logic   is_div;
		logic   rd_on_b;
	} queue_entry_t;

	typedef struct packed {
		logic        stop_code;
		logic [63:0] next_pc;
		logic [3:0]  flags;
		logic [63:0] written_value;
		logic [4:0]  written_reg;
		logic        write_valid;
	} result_t;

endpackage

// ===== hw/rtl/arm64_integer_execute_unit.sv =====
// top level of the integer execute unit: front queue and back end
//
// channel   dir  width  contents
// s_axis    in   232    one pre-decoded instruction
// m_axis    out  144    one retirement record per instruction
//
// in the back end an instruction goes through register read, then execute
// udiv/sdiv with a nonzero divisor wait in the back end for the bit-serial divider
// a two-entry queue keeps accepting, until it is full, while the back end works or the result waits
// a full result register holds the back end until m_tready takes the record
// reset clears the registers through per-entry valid bits at once, and sp, flags and pc directly
module arm64_integer_execute_unit import aie_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op, is_64bit, dest_reg, first_reg, second_reg, immediate, shift_kind,
	// shift_amount, bit_index, field_write_mask, field_top_mask, condition
	input  logic [231:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// write_valid, written_reg, written_value, flags, next_pc, stop_code, zero pad
	output logic [143:0] m_tdata
);

	instr_t       in_ins;
	logic         q_valid, q_pop;
	queue_entry_t q_head;
	result_t      res;

	assign in_ins = s_tdata;

	aie_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_ins   (in_ins),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_head   (q_head)
	);

	aie_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {5'b0, res};

endmodule

// ===== hw/rtl/aie_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
module aie_front import aie_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  instr_t       in_ins,
	output logic         q_valid,
	input  logic         q_pop,
	output queue_entry_t q_head
);

	queue_entry_t q_mem [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	queue_entry_t new_entry;
	logic         push;

	always_comb begin
		new_entry.ins     = in_ins;
		new_entry.is_div  = (in_ins.op == OP_UDIV) || (in_ins.op == OP_SDIV);
		// bitfield insert and keep-move read the destination on port b
		new_entry.rd_on_b = (in_ins.op == OP_BFM) || (in_ins.op == OP_MOVK);
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== hw/rtl/aie_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module aie_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  count_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] rem_sh;
	logic        ge;

	assign rem_sh   = {rem_q, quo_q[63]};
	assign ge       = rem_sh >= {1'b0, den_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= 7'd0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= 7'd0;
		end else if (busy_q) begin
			count_q <= count_q + 7'd1;
			if (count_q == 7'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/aie_back.sv =====
// back end: register file, execute logic, divider control and result register
module aie_back import aie_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_pop,
	input  queue_entry_t q_head,
	output logic         out_valid,
	input  logic         out_ready,
	output result_t      out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIVW = 2'd2;

	logic [1:0]   state_q;
	queue_entry_t cur_q;
	logic [63:0]  rf_mem [32];
	logic [31:0]  rf_vld_q;
	logic [63:0]  ra_mem_q, rb_mem_q;
	logic         ra_vld_q, rb_vld_q;
	logic [63:0]  sp_q, pc_q;
	logic [3:0]   flags_q;
	logic         out_valid_q;
	result_t      out_q;

	logic [4:0]   b_addr;
	logic         slot_free, wb_go, div_start, div_busy, div_done;
	logic [63:0]  div_quo, div_num, div_den;
	result_t      wb;

	function automatic logic sbit(input logic [63:0] x, input logic w64);
		sbit = w64 ? x[63] : x[31];
	endfunction

	function automatic logic [63:0] shf(input logic [63:0] v_in, input logic w64,
	                                    input logic [1:0] kind, input logic [5:0] amt);
		logic [63:0]  v;
		logic [127:0] dbl;
		logic [5:0]   a;
		logic         over;
		logic [63:0]  r;
		v    = w64 ? v_in : {32'h0, v_in[31:0]};
		over = !w64 && amt[5];
		a    = w64 ? amt : {1'b0, amt[4:0]};
		unique case (kind)
			SH_ROR: begin
				dbl = w64 ? {v, v} : {64'h0, v[31:0], v[31:0]};
				dbl = dbl >> a;
				r   = w64 ? dbl[63:0] : {32'h0, dbl[31:0]};
			end
			SH_LSL: r = over ? 64'h0 : (v << amt);
			SH_LSR: r = over ? 64'h0 : (v >> amt);
			default: begin
				if (w64) begin
					r = 64'($signed(v) >>> amt);
				end else begin
					r = over ? {64{v[31]}} : {32'h0, 32'($signed(v[31:0]) >>> amt[4:0])};
				end
			end
		endcase
		shf = w64 ? r : {32'h0, r[31:0]};
	endfunction

	function automatic logic cond_holds(input logic [3:0] f, input logic [3:0] cond);
		logic n, z, c, v, r;
		n = f[3];
		z = f[2];
		c = f[1];
		v = f[0];
		unique case (cond[3:1])
			3'd0: r = z;
			3'd1: r = c;
			3'd2: r = n;
			3'd3: r = v;
			3'd4: r = c && !z;
			3'd5: r = n == v;
			3'd6: r = (n == v) && !z;
			default: r = 1'b1;
		endcase
		if (cond[0] && cond != 4'hf) begin
			r = !r;
		end
		cond_holds = r;
	endfunction

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign b_addr    = q_head.rd_on_b ? q_head.ins.dest_reg : q_head.ins.second_reg;
	assign slot_free = !out_valid_q || out_ready;

	// register file reads issued as the request leaves the queue
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q    <= q_head;
			ra_mem_q <= rf_mem[q_head.ins.first_reg];
			rb_mem_q <= rf_mem[b_addr];
		end
		if (wb_go && wb.write_valid && wb.written_reg != REG_ZR_SP) begin
			rf_mem[wb.written_reg] <= wb.written_value;
		end
	end

	// execute
	instr_t      i;
	logic        w64, sp_ok, sub, setf, is_logic_reg, invert, hold_cond, den_zero;
	logic [63:0] mask, ra, rb, rn_sp, al, ar, sum_l, diff, res, val, bot, top, mw;
	logic [64:0] sum;
	logic [1:0]  lkind;
	logic [3:0]  nflags;
	logic [63:0] npc, pc4, ma, mb, sq;
	logic        do_write, na, nb;
	logic [4:0]  wreg;

	always_comb begin
		i        = cur_q.ins;
		w64      = i.is_64bit;
		mask     = w64 ? {64{1'b1}} : {32'h0, {32{1'b1}}};
		ra       = (i.first_reg == REG_ZR_SP || !ra_vld_q) ? 64'h0 : ra_mem_q;
		rb       = (!rb_vld_q || (cur_q.rd_on_b ? i.dest_reg : i.second_reg) == REG_ZR_SP)
		           ? 64'h0 : rb_mem_q;
		rn_sp    = (i.first_reg == REG_ZR_SP) ? sp_q : ra;
		pc4      = pc_q + 64'd4;
		npc      = pc4;
		nflags   = flags_q;
		hold_cond = cond_holds(flags_q, i.condition);

		// shared adder and subtractor for the add/sub forms
		sub  = (i.op == OP_SUB_IMM) || (i.op == OP_SUBS_IMM) ||
		       (i.op == OP_SUB_REG) || (i.op == OP_SUBS_REG);
		setf = (i.op == OP_ADDS_IMM) || (i.op == OP_SUBS_IMM) ||
		       (i.op == OP_ADDS_REG) || (i.op == OP_SUBS_REG);
		al   = ((i.op <= OP_SUBS_IMM) ? rn_sp : ra) & mask;
		ar   = ((i.op <= OP_SUBS_IMM) ? i.immediate
		        : shf(rb, w64, i.shift_kind, i.shift_amount)) & mask;
		sum  = {1'b0, al} + {1'b0, ar};
		diff = al - ar;
		sum_l = (sub ? diff : sum[63:0]) & mask;

		// logical forms
		is_logic_reg = i.op < OP_AND_IMM;
		invert = (i.op >= OP_BIC) && is_logic_reg;
		lkind  = is_logic_reg ? (invert ? 2'(i.op - OP_BIC) : 2'(i.op - OP_AND))
		                      : 2'(i.op - OP_AND_IMM);
		mw     = is_logic_reg ? shf(rb, w64, i.shift_kind, i.shift_amount)
		                      : (i.immediate & mask);
		if (invert) begin
			mw = ~mw & mask;
		end

		// divide operands
		na = (i.op == OP_SDIV) && sbit(ra & mask, w64);
		nb = (i.op == OP_SDIV) && sbit(rb & mask, w64);
		ma = na ? ((64'h0 - ra) & mask) : (ra & mask);
		mb = nb ? ((64'h0 - rb) & mask) : (rb & mask);
		den_zero = (rb & mask) == 64'h0;
		sq = (na != nb) ? ((64'h0 - div_quo) & mask) : div_quo;

		bot      = 64'h0;
		top      = 64'h0;
		res      = 64'h0;
		val      = 64'h0;
		do_write = 1'b0;
		sp_ok    = 1'b0;
		wreg     = i.dest_reg;

		priority if (i.op >= OP_ADD_IMM && i.op <= OP_SUBS_REG) begin
			do_write = 1'b1;
			sp_ok    = (i.op == OP_ADD_IMM) || (i.op == OP_SUB_IMM);
			val      = sum_l;
			if (setf) begin
				nflags[3] = sbit(sum_l, w64);
				nflags[2] = sum_l == 64'h0;
				nflags[1] = sub ? (al >= ar) : (w64 ? sum[64] : sum[32]);
				nflags[0] = sub ? ((sbit(al, w64) ^ sbit(ar, w64)) &
				                   (sbit(al, w64) ^ sbit(sum_l, w64)))
				                : (~(sbit(al, w64) ^ sbit(ar, w64)) &
				                   (sbit(al, w64) ^ sbit(sum_l, w64)));
			end
		end else if (i.op >= OP_AND && i.op <= OP_ANDS_IMM) begin
			do_write = 1'b1;
			unique case (lkind)
				2'd1: res = ra | mw;
				2'd2: res = ra ^ mw;
				default: res = ra & mw;
			endcase
			val      = res & mask;
			sp_ok    = !is_logic_reg && lkind != 2'd3;
			if (lkind == 2'd3) begin
				nflags = {sbit(val, w64), val == 64'h0, 2'b00};
			end
		end else if (i.op >= OP_SBFM && i.op <= OP_UBFM) begin
			do_write = 1'b1;
			bot = shf(ra, w64, SH_ROR, i.shift_amount) & i.field_write_mask;
			if (i.op == OP_SBFM) begin
				top = ((ra & mask) >> i.bit_index) & 64'h1;
				top = (top != 64'h0) ? mask : 64'h0;
				val = (top & ~i.field_top_mask) | (bot & i.field_top_mask);
			end else if (i.op == OP_BFM) begin
				bot = bot | (rb & mask & ~i.field_write_mask);
				val = (rb & mask & ~i.field_top_mask) | (bot & i.field_top_mask);
			end else begin
				val = bot & i.field_top_mask;
			end
		end else if (i.op >= OP_MOVN && i.op <= OP_MOVK) begin
			do_write = 1'b1;
			val = {48'h0, i.immediate[15:0]} << i.shift_amount;
			if (i.op == OP_MOVN) begin
				val = ~val;
			end else if (i.op == OP_MOVK) begin
				val = val | (rb & mask & ~(64'hffff << i.shift_amount));
			end
		end else if (i.op == OP_ADR || i.op == OP_ADRP) begin
			do_write = 1'b1;
			mask     = {64{1'b1}};
			val = ((i.op == OP_ADRP) ? (pc_q & ~64'hfff) : pc_q) + i.immediate;
		end else if (i.op >= OP_CSEL && i.op <= OP_CSNEG) begin
			do_write = 1'b1;
			if (hold_cond) begin
				val = ra;
			end else begin
				unique case (i.op)
					OP_CSINC: val = rb + 64'd1;
					OP_CSINV: val = ~rb;
					OP_CSNEG: val = 64'h0 - rb;
					default:  val = rb;
				endcase
			end
		end else if (i.op == OP_UDIV || i.op == OP_SDIV) begin
			do_write = 1'b1;
			val = den_zero ? 64'h0 : sq;
		end else if (i.op >= OP_LSLV && i.op <= OP_RORV) begin
			do_write = 1'b1;
			val = shf(ra, w64, 2'(i.op - OP_LSLV),
			          w64 ? rb[5:0] : {1'b0, rb[4:0]});
		end else if (i.op == OP_B || i.op == OP_BL) begin
			npc = pc_q + i.immediate;
			do_write = i.op == OP_BL;
			wreg = REG_LINK;
			val  = pc4;
			mask = {64{1'b1}};
		end else if (i.op >= OP_BR && i.op <= OP_RET) begin
			npc = ra;
			do_write = i.op == OP_BLR;
			wreg = REG_LINK;
			val  = pc4;
			mask = {64{1'b1}};
		end else if (i.op == OP_BCOND) begin
			if (hold_cond) begin
				npc = pc_q + i.immediate;
			end
		end else if (i.op == OP_CBZ || i.op == OP_CBNZ) begin
			if (((rb & mask) == 64'h0) == (i.op == OP_CBZ)) begin
				npc = pc_q + i.immediate;
			end
		end else if (i.op == OP_TBZ || i.op == OP_TBNZ) begin
			if (rb[i.bit_index] == (i.op == OP_TBNZ)) begin
				npc = pc_q + i.immediate;
			end
		end else begin
		end

		wb.write_valid   = do_write && (wreg != REG_ZR_SP || sp_ok);
		wb.written_reg   = wb.write_valid ? wreg : 5'd0;
		wb.written_value = wb.write_valid ? (val & mask) : 64'h0;
		wb.flags         = nflags;
		wb.next_pc       = npc;
		wb.stop_code     = i.op == OP_SVC;
	end

	assign div_num   = ma;
	assign div_den   = mb;
	assign div_start = (state_q == ST_EXEC) && cur_q.is_div && !den_zero;
	assign wb_go     = slot_free &&
	                   (((state_q == ST_EXEC) && !(cur_q.is_div && !den_zero)) ||
	                    ((state_q == ST_DIVW) && div_done));

	aie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_q <= wb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rf_vld_q    <= 32'h0;
			ra_vld_q    <= 1'b0;
			rb_vld_q    <= 1'b0;
			sp_q        <= 64'h0;
			pc_q        <= 64'h0;
			flags_q     <= 4'h0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				ra_vld_q <= rf_vld_q[q_head.ins.first_reg];
				rb_vld_q <= rf_vld_q[b_addr];
			end
			out_valid_q <= wb_go || (out_valid_q && !out_ready);
			if (wb_go) begin
				pc_q        <= wb.next_pc;
				flags_q     <= wb.flags;
				if (wb.write_valid) begin
					if (wb.written_reg == REG_ZR_SP) begin
						sp_q <= wb.written_value;
					end else begin
						rf_vld_q[wb.written_reg] <= 1'b1;
					end
				end
			end
			unique case (state_q)
				ST_IDLE: if (q_pop) begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (div_start) begin
						state_q <= ST_DIVW;
					end else if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIVW: if (wb_go) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !q_valid) |=> (state_q == ST_IDLE))
		else $error("back end left idle with an empty queue");
	a_wb_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_go && !wb.write_valid) |-> (wb.written_reg == 5'd0 && wb.written_value == 64'h0))
		else $error("no-write result carries register data");
	a_div_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVW) |-> (div_busy || div_done))
		else $error("waiting on an idle divider");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE))
		else $error("queue popped while executing");

endmodule

// ===== sim/arm64_integer_execute_unit_checker.sv =====
// retirement checker: predicts each instruction's record and compares it with the output
`timescale 1ns / 1ps
module arm64_integer_execute_unit_checker import aie_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [231:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [143:0] m_tdata,
	output int           errors,
	output int           pending
);

	logic [63:0] gpr [0:30];
	logic [63:0] sp_val;
	logic [3:0]  nzcv;
	logic [63:0] pc;

	logic        wr_done;
	logic [4:0]  wr_num;
	logic [63:0] wr_data;

	result_t retire_q [$];

	function automatic logic [63:0] wmask_of(input logic w64);
		return w64 ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
	endfunction

	function automatic logic [63:0] sign_bit(input logic w64);
		return w64 ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
	endfunction

	function automatic logic [63:0] read_reg(input logic [4:0] n, input logic w64,
			input logic sp_ok);
		logic [63:0] v;
		if (n == REG_ZR_SP)
			v = sp_ok ? sp_val : 64'd0;
		else
			v = gpr[n];
		return v & wmask_of(w64);
	endfunction

	task automatic write_reg(input logic [4:0] n, input logic w64, input logic sp_ok,
			input logic [63:0] v);
		logic [63:0] m;
		m = v & wmask_of(w64);
		if (n == REG_ZR_SP) begin
			if (!sp_ok)
				return;
			sp_val = m;
		end else begin
			gpr[n] = m;
		end
		wr_done = 1'b1;
		wr_num = n;
		wr_data = m;
	endtask

	function automatic logic [63:0] shift_op(input logic [63:0] v_in, input logic w64,
			input logic [1:0] kind, input int unsigned amt_in);
		int unsigned width, amt;
		logic [63:0] m, v, s;
		width = w64 ? 64 : 32;
		m = wmask_of(w64);
		v = v_in & m;
		amt = amt_in;
		if (kind == SH_ROR) begin
			amt = amt & (width - 1);
			if (amt == 0)
				return v;
			return ((v >> amt) | (v << (width - amt))) & m;
		end
		if (amt == 0)
			return v;
		if (amt >= width) begin
			if (kind == SH_ASR)
				return (v & sign_bit(w64)) != 0 ? m : 64'd0;
			return 64'd0;
		end
		if (kind == SH_LSL)
			return (v << amt) & m;
		if (kind == SH_LSR)
			return v >> amt;
		s = v >> amt;
		if ((v & sign_bit(w64)) != 0)
			s = s | (m << (width - amt));
		return s & m;
	endfunction

	task automatic set_nz(input logic [63:0] res, input logic w64, input logic c,
			input logic v);
		nzcv = {(res & sign_bit(w64)) != 0, (res & wmask_of(w64)) == 0, c, v};
	endtask

	task automatic add_sub(input logic [63:0] l_in, input logic [63:0] r_in, input logic sub,
			input logic w64, input logic setf, output logic [63:0] res);
		logic [63:0] m, sg, l, r;
		logic [64:0] sum;
		logic c, v;
		m = wmask_of(w64);
		sg = sign_bit(w64);
		l = l_in & m;
		r = r_in & m;
		sum = {1'b0, l} + {1'b0, r};
		res = (sub ? l - r : l + r) & m;
		if (setf) begin
			if (sub) begin
				c = l >= r;
				v = ((l ^ r) & (l ^ res) & sg) != 0;
			end else begin
				c = w64 ? sum[64] : sum[32];
				v = (~(l ^ r) & (l ^ res) & sg) != 0;
			end
			set_nz(res, w64, c, v);
		end
	endtask

	function automatic logic cond_true(input logic [3:0] cond);
		logic n, z, c, v, r;
		{n, z, c, v} = nzcv;
		case (cond[3:1])
			3'd0: r = z;
			3'd1: r = c;
			3'd2: r = n;
			3'd3: r = v;
			3'd4: r = c && !z;
			3'd5: r = n == v;
			3'd6: r = (n == v) && !z;
			default: r = 1'b1;
		endcase
		if (cond[0] && cond != 4'd15)
			r = !r;
		return r;
	endfunction

	function automatic logic [63:0] signed_quot(input logic [63:0] a_in, input logic [63:0] b_in,
			input logic w64);
		logic [63:0] m, sg, a, b, ma, mb, q;
		logic na, nb;
		m = wmask_of(w64);
		sg = sign_bit(w64);
		a = a_in & m;
		b = b_in & m;
		na = (a & sg) != 0;
		nb = (b & sg) != 0;
		ma = na ? (64'd0 - a) & m : a;
		mb = nb ? (64'd0 - b) & m : b;
		if (mb == 0)
			return 64'd0;
		q = ma / mb;
		if (na != nb)
			q = (64'd0 - q) & m;
		return q;
	endfunction

	// runs one instruction against the kept state and returns its record
	task automatic retire_instr(input instr_t i, output result_t rec);
		logic w;
		logic [63:0] m, pc4, npc, l, r, res, src, bot, top, dst, v;
		logic sub, setf, imm_form, bit_set, take;
		logic [1:0] kind;
		w = i.is_64bit;
		m = wmask_of(w);
		pc4 = pc + 64'd4;
		npc = pc4;
		wr_done = 1'b0;
		wr_num = '0;
		wr_data = '0;
		rec = '0;
		if (i.op >= OP_ADD_IMM && i.op <= OP_SUBS_IMM) begin
			sub = i.op >= OP_SUB_IMM;
			setf = i.op == OP_ADDS_IMM || i.op == OP_SUBS_IMM;
			add_sub(read_reg(i.first_reg, w, 1'b1), i.immediate, sub, w, setf, res);
			write_reg(i.dest_reg, w, !setf, res);
		end else if (i.op >= OP_ADD_REG && i.op <= OP_SUBS_REG) begin
			sub = i.op >= OP_SUB_REG;
			setf = i.op == OP_ADDS_REG || i.op == OP_SUBS_REG;
			r = shift_op(read_reg(i.second_reg, w, 1'b0), w, i.shift_kind,
				32'(i.shift_amount));
			add_sub(read_reg(i.first_reg, w, 1'b0), r, sub, w, setf, res);
			write_reg(i.dest_reg, w, 1'b0, res);
		end else if (i.op >= OP_AND && i.op <= OP_ANDS_IMM) begin
			l = read_reg(i.first_reg, w, 1'b0);
			imm_form = i.op >= OP_AND_IMM;
			if (imm_form) begin
				r = i.immediate & m;
				kind = 2'(i.op - OP_AND_IMM);
			end else begin
				r = shift_op(read_reg(i.second_reg, w, 1'b0), w, i.shift_kind,
					32'(i.shift_amount));
				if (i.op >= OP_BIC) begin
					r = ~r & m;
					kind = 2'(i.op - OP_BIC);
				end else begin
					kind = 2'(i.op - OP_AND);
				end
			end
			// kind: and, or, xor, and with flags
			if (kind == 2'd1)
				res = l | r;
			else if (kind == 2'd2)
				res = l ^ r;
			else
				res = l & r;
			res = res & m;
			if (kind == 2'd3)
				set_nz(res, w, 1'b0, 1'b0);
			write_reg(i.dest_reg, w, imm_form && kind != 2'd3, res);
		end else if (i.op >= OP_SBFM && i.op <= OP_UBFM) begin
			src = read_reg(i.first_reg, w, 1'b0);
			bot = shift_op(src, w, SH_ROR, 32'(i.shift_amount)) & i.field_write_mask;
			if (i.op == OP_SBFM) begin
				top = src[i.bit_index] ? m : 64'd0;
				res = (top & ~i.field_top_mask) | (bot & i.field_top_mask);
			end else if (i.op == OP_BFM) begin
				dst = read_reg(i.dest_reg, w, 1'b0);
				bot = bot | (dst & ~i.field_write_mask);
				res = (dst & ~i.field_top_mask) | (bot & i.field_top_mask);
			end else begin
				res = bot & i.field_top_mask;
			end
			write_reg(i.dest_reg, w, 1'b0, res);
		end else if (i.op >= OP_MOVN && i.op <= OP_MOVK) begin
			v = {48'd0, i.immediate[15:0]} << i.shift_amount;
			if (i.op == OP_MOVN)
				v = ~v;
			else if (i.op == OP_MOVK)
				v = v | (read_reg(i.dest_reg, w, 1'b0) & ~(64'hffff << i.shift_amount));
			write_reg(i.dest_reg, w, 1'b0, v);
		end else if (i.op == OP_ADR || i.op == OP_ADRP) begin
			v = i.op == OP_ADRP ? (pc & ~64'hfff) : pc;
			write_reg(i.dest_reg, 1'b1, 1'b0, v + i.immediate);
		end else if (i.op >= OP_CSEL && i.op <= OP_CSNEG) begin
			if (cond_true(i.condition)) begin
				res = read_reg(i.first_reg, w, 1'b0);
			end else begin
				res = read_reg(i.second_reg, w, 1'b0);
				if (i.op == OP_CSINC)
					res = res + 64'd1;
				else if (i.op == OP_CSINV)
					res = ~res;
				else if (i.op == OP_CSNEG)
					res = 64'd0 - res;
				res = res & m;
			end
			write_reg(i.dest_reg, w, 1'b0, res);
		end else if (i.op >= OP_UDIV && i.op <= OP_RORV) begin
			l = read_reg(i.first_reg, w, 1'b0);
			r = read_reg(i.second_reg, w, 1'b0);
			if (i.op == OP_UDIV)
				res = r == 0 ? 64'd0 : l / r;
			else if (i.op == OP_SDIV)
				res = signed_quot(l, r, w);
			else
				res = shift_op(l, w, 2'(i.op - OP_LSLV), 32'(r & (w ? 64'd63 : 64'd31)));
			write_reg(i.dest_reg, w, 1'b0, res);
		end else if (i.op == OP_B || i.op == OP_BL) begin
			if (i.op == OP_BL)
				write_reg(REG_LINK, 1'b1, 1'b0, pc4);
			npc = pc + i.immediate;
		end else if (i.op >= OP_BR && i.op <= OP_RET) begin
			v = read_reg(i.first_reg, 1'b1, 1'b0);
			if (i.op == OP_BLR)
				write_reg(REG_LINK, 1'b1, 1'b0, pc4);
			npc = v;
		end else if (i.op == OP_BCOND) begin
			if (cond_true(i.condition))
				npc = pc + i.immediate;
		end else if (i.op == OP_CBZ || i.op == OP_CBNZ) begin
			v = read_reg(i.second_reg, w, 1'b0);
			take = i.op == OP_CBZ ? v == 0 : v != 0;
			if (take)
				npc = pc + i.immediate;
		end else if (i.op == OP_TBZ || i.op == OP_TBNZ) begin
			v = read_reg(i.second_reg, 1'b1, 1'b0);
			bit_set = v[i.bit_index];
			take = i.op == OP_TBZ ? !bit_set : bit_set;
			if (take)
				npc = pc + i.immediate;
		end else if (i.op == OP_SVC) begin
			rec.stop_code = 1'b1;
		end
		pc = npc;
		rec.write_valid = wr_done;
		rec.written_reg = wr_num;
		rec.written_value = wr_data;
		rec.flags = nzcv;
		rec.next_pc = pc;
	endtask

	task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			for (int k = 0; k < 31; k++)
				gpr[k] = '0;
			sp_val = '0;
			nzcv = '0;
			pc = '0;
			retire_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				retire_instr(instr_t'(s_tdata), want);
				retire_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[138:0]);
				if (retire_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("record with nothing outstanding: %h", m_tdata);
				end else begin
					want = retire_q.pop_front();
					if (got.write_valid != want.write_valid)
						report("write_valid", want.write_valid, got.write_valid);
					if (got.written_reg != want.written_reg)
						report("written_reg", want.written_reg, got.written_reg);
					if (got.written_value != want.written_value)
						report("written_value", want.written_value, got.written_value);
					if (got.flags != want.flags)
						report("flags", want.flags, got.flags);
					if (got.next_pc != want.next_pc)
						report("next_pc", want.next_pc, got.next_pc);
					if (got.stop_code != want.stop_code)
						report("stop_code", want.stop_code, got.stop_code);
				end
			end
			pending = retire_q.size();
		end
	end

endmodule

// ===== sim/tb_arm64_integer_execute_unit.sv =====
// testbench top: instruction stimulus, output backpressure and the verdict
`timescale 1ns / 1ps
module tb_arm64_integer_execute_unit import aie_pkg::*;;

	localparam logic [5:0] OP_NOP    = 6'd0;
	localparam logic [5:0] OP_UNUSED = 6'd63;
	localparam int N_RANDOM = 900;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [231:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	int           errors;
	int           pending;
	int           cycles = 0;
	logic         calm;

	arm64_integer_execute_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	arm64_integer_execute_unit_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// backpressure on the result side, off near the end
	always @(posedge clk) begin
		if (arst_n && !calm && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic instr_t mk(input logic [5:0] op, input logic w64, input logic [4:0] rd,
			input logic [4:0] rn, input logic [4:0] rm, input logic [63:0] imm);
		instr_t i;
		i = '0;
		i.op = op;
		i.is_64bit = w64;
		i.dest_reg = rd;
		i.first_reg = rn;
		i.second_reg = rm;
		i.immediate = imm;
		i.condition = 4'd14;
		return i;
	endfunction

	function automatic logic [4:0] pick_reg();
		int unsigned p;
		p = $urandom_range(0, 9);
		if (p == 0)
			return REG_ZR_SP;
		if (p == 1)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, 7));
	endfunction

	function automatic instr_t rand_instr();
		instr_t i;
		int unsigned p;
		i.op = 6'($urandom_range(1, 49));
		p = $urandom_range(0, 99);
		if (p < 3)
			i.op = 6'($urandom_range(50, 63));
		else if (p < 5)
			i.op = OP_NOP;
		else if ((i.op == OP_UDIV || i.op == OP_SDIV) && p < 60)
			i.op = OP_LSLV;
		i.is_64bit = $urandom_range(0, 3) != 0;
		i.dest_reg = pick_reg();
		i.first_reg = pick_reg();
		i.second_reg = pick_reg();
		p = $urandom_range(0, 3);
		if (i.op >= OP_B && i.op <= OP_TBNZ || i.op == OP_ADR || i.op == OP_ADRP)
			i.immediate = p == 0 ? rand64() : 64'($signed(20'($urandom)) * 4);
		else if (p == 0)
			i.immediate = 64'($urandom_range(0, 4095));
		else if (p == 1)
			i.immediate = rand64() | 64'h8000_0000_0000_0000;
		else
			i.immediate = rand64();
		i.shift_kind = 2'($urandom);
		i.shift_amount = 6'($urandom);
		if (i.op >= OP_MOVN && i.op <= OP_MOVK && $urandom_range(0, 1) == 0)
			i.shift_amount = 6'(16 * $urandom_range(0, 3));
		i.bit_index = 6'($urandom);
		i.field_write_mask = $urandom_range(0, 1) ? rand64() : ~64'd0 >> $urandom_range(0, 63);
		i.field_top_mask = $urandom_range(0, 1) ? rand64() : ~64'd0 >> $urandom_range(0, 63);
		i.condition = 4'($urandom);
		return i;
	endfunction

	task automatic send(input instr_t i);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= i;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		instr_t d [$];
		instr_t t;
		int hold;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: operand extremes and the corner cases
		d.push_back(mk(OP_MOVN, 1'b1, 5'd2, 5'd0, 5'd0, 64'd0));
		d.push_back(mk(OP_MOVZ, 1'b1, 5'd1, 5'd0, 5'd0, 64'h8000));
		d[$].shift_amount = 6'd48;
		d.push_back(mk(OP_SDIV, 1'b1, 5'd3, 5'd1, 5'd2, 64'd0));
		d.push_back(mk(OP_SDIV, 1'b0, 5'd3, 5'd2, 5'd2, 64'd0));
		d.push_back(mk(OP_UDIV, 1'b1, 5'd4, 5'd2, 5'd5, 64'd0));
		d.push_back(mk(OP_ADD_IMM, 1'b1, REG_ZR_SP, 5'd2, 5'd0, 64'hfff));
		d.push_back(mk(OP_SUB_IMM, 1'b1, 5'd6, REG_ZR_SP, 5'd0, 64'd1));
		d.push_back(mk(OP_ADDS_IMM, 1'b1, REG_ZR_SP, 5'd2, 5'd0, 64'd1));
		d.push_back(mk(OP_SUBS_IMM, 1'b0, 5'd7, 5'd1, 5'd0, ~64'd0));
		d.push_back(mk(OP_ADDS_REG, 1'b1, 5'd8, 5'd1, 5'd1, 64'd0));
		d.push_back(mk(OP_SUBS_REG, 1'b1, 5'd9, 5'd2, 5'd1, 64'd0));
		d[$].shift_kind = SH_ASR;
		d[$].shift_amount = 6'd63;
		d.push_back(mk(OP_AND, 1'b0, 5'd10, 5'd2, 5'd2, 64'd0));
		d[$].shift_kind = SH_LSL;
		d[$].shift_amount = 6'd40;
		d.push_back(mk(OP_BICS, 1'b1, 5'd11, 5'd2, 5'd1, 64'd0));
		d.push_back(mk(OP_EOR_IMM, 1'b0, REG_ZR_SP, 5'd2, 5'd0, ~64'd0));
		d.push_back(mk(OP_SBFM, 1'b0, 5'd12, 5'd2, 5'd0, 64'd0));
		d[$].bit_index = 6'd40;
		d[$].shift_amount = 6'd35;
		d[$].field_write_mask = ~64'd0;
		d[$].field_top_mask = 64'hff;
		d.push_back(mk(OP_BFM, 1'b1, 5'd12, 5'd1, 5'd0, 64'd0));
		d[$].field_write_mask = 64'hffff_0000;
		d[$].field_top_mask = 64'h00ff_ff00;
		d.push_back(mk(OP_RORV, 1'b0, 5'd13, 5'd1, 5'd2, 64'd0));
		d.push_back(mk(OP_ADRP, 1'b1, 5'd14, 5'd0, 5'd0, 64'h7fff_f000));
		d.push_back(mk(OP_CSNEG, 1'b1, 5'd15, 5'd1, 5'd2, 64'd0));
		d[$].condition = 4'd15;
		d.push_back(mk(OP_BL, 1'b1, 5'd0, 5'd0, 5'd0, 64'hffff_ffff_ffff_fffc));
		d.push_back(mk(OP_TBNZ, 1'b1, 5'd0, 5'd0, 5'd1, 64'd64));
		d[$].bit_index = 6'd63;
		d.push_back(mk(OP_BLR, 1'b1, 5'd0, REG_ZR_SP, 5'd0, 64'd0));
		d.push_back(mk(OP_SVC, 1'b1, 5'd0, 5'd0, 5'd0, 64'd0));
		d.push_back(mk(OP_UNUSED, 1'b1, 5'd3, 5'd3, 5'd3, ~64'd0));
		foreach (d[k])
			send(d[k]);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				// hold the sender until every retirement record has come back
				s_tvalid <= 1'b0;
				do
					@(posedge clk);
				while (pending != 0);
			end
			if (n == N_RANDOM * 7 / 8)
				calm = 1'b1;
			t = rand_instr();
			send(t);
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		hold = 0;
		while (hold < 100) begin
			@(posedge clk);
			hold++;
		end
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== arm64_integer_execute_unit.f =====
hw/rtl/aie_pkg.sv
hw/rtl/aie_front.sv
hw/rtl/aie_div.sv
hw/rtl/aie_back.sv
hw/rtl/arm64_integer_execute_unit.sv
sim/arm64_integer_execute_unit_checker.sv
sim/tb_arm64_integer_execute_unit.sv
